// ===== sv/bpc_pkg.sv =====
// bpc_pkg: shared types and codes for the button press classifier
// phase codes, result kinds, configuration register indexes and structs
// no dependencies
package bpc_pkg;

	localparam int TIMER_BITS_DEF = 16;
	localparam int PHASE_W = 3;
	localparam int KIND_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_SETTLE1 = 3'd1;
	localparam logic [PHASE_W-1:0] PH_HOLD1   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_WINDOW  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_SETTLE2 = 3'd4;
	localparam logic [PHASE_W-1:0] PH_HOLD2   = 3'd5;
	localparam logic [PHASE_W-1:0] PH_DRAIN   = 3'd6;

	localparam logic [KIND_W-1:0] KIND_SHORT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LONG   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DOUBLE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 2'd2;

	localparam logic [15:0] LONG_PRESS_RST   = 16'd3000;
	localparam logic [15:0] DOUBLE_CLICK_RST = 16'd400;
	localparam logic [7:0]  DEBOUNCE_RST     = 8'd20;

	typedef struct packed {
		logic [15:0] long_press_ticks;
		logic [15:0] double_click_ticks;
		logic [7:0]  debounce_ticks;
	} cfg_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic               emit;
		logic [KIND_W-1:0]  kind;
	} step_res_t;

endpackage

// ===== sv/bpc_cfg_regs.sv =====
// bpc_cfg_regs: the three threshold registers of the classifier
// depends on bpc_pkg
module bpc_cfg_regs import bpc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ticks   <= LONG_PRESS_RST;
			cfg_q.double_click_ticks <= DOUBLE_CLICK_RST;
			cfg_q.debounce_ticks     <= DEBOUNCE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LONG_PRESS:   cfg_q.long_press_ticks   <= cfg_data;
				REG_DOUBLE_CLICK: cfg_q.double_click_ticks <= cfg_data;
				REG_DEBOUNCE:     cfg_q.debounce_ticks     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/bpc_in_stage.sv =====
// bpc_in_stage: input register for the button sample
// depends on bpc_pkg
module bpc_in_stage import bpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic pressed,
	input  logic advance,
	output logic valid_s1,
	output logic pressed_s1
);

	logic valid_q;
	logic pressed_q;

	// stage frees up when its word moves on
	assign in_ready = !valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pressed_q <= pressed;
		end
	end

	assign valid_s1   = valid_q;
	assign pressed_s1 = pressed_q;

endmodule

// ===== sv/bpc_step.sv =====
// bpc_step: next phase, timer and result for one button sample
// depends on bpc_pkg
module bpc_step import bpc_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  cfg_t                  cfg,
	input  logic [PHASE_W-1:0]    phase,
	input  logic [TIMER_BITS-1:0] elapsed,
	input  logic                  pressed,
	output step_res_t             res,
	output logic [TIMER_BITS-1:0] elapsed_next
);

	localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

	logic [TIMER_BITS-1:0] e_t;
	logic [CW-1:0]         e_w;
	logic                  second;
	logic                  deb_zero;
	logic                  long_zero;
	logic                  dct_zero;
	logic                  settled;
	logic                  long_hit;
	logic                  win_over;
	logic [KIND_W-1:0]     held_kind;

	// saturating tick
	assign e_t       = (&elapsed) ? elapsed : elapsed + 1'b1;
	assign e_w       = CW'(e_t);
	assign second    = (phase == PH_SETTLE2) || (phase == PH_HOLD2);
	assign deb_zero  = (cfg.debounce_ticks == 8'd0);
	assign long_zero = (cfg.long_press_ticks == 16'd0);
	assign dct_zero  = (cfg.double_click_ticks == 16'd0);
	assign settled   = (e_w >= CW'(cfg.debounce_ticks));
	assign long_hit  = (e_w >= CW'(cfg.long_press_ticks));
	assign win_over  = (e_w >= CW'(cfg.double_click_ticks));
	assign held_kind = second ? KIND_DOUBLE : KIND_LONG;

	always_comb begin
		res.phase    = phase;
		res.emit     = 1'b0;
		res.kind     = KIND_SHORT;
		elapsed_next = elapsed;
		case (phase)
			PH_SETTLE1, PH_SETTLE2: begin
				elapsed_next = e_t;
				if (settled) begin
					if (!pressed) begin
						if (second) begin
							res.emit  = 1'b1;
							res.kind  = KIND_DOUBLE;
							res.phase = PH_IDLE;
						end else begin
							// open double-click window
							elapsed_next = '0;
							res.phase    = dct_zero ? PH_IDLE : PH_WINDOW;
							res.emit     = dct_zero;
						end
					end else begin
						elapsed_next = '0;
						res.phase    = second ? PH_HOLD2 : PH_HOLD1;
						if (long_zero) begin
							res.emit  = 1'b1;
							res.kind  = held_kind;
							res.phase = PH_DRAIN;
						end
					end
				end
			end
			PH_HOLD1, PH_HOLD2: begin
				elapsed_next = e_t;
				if (!pressed) begin
					if (second) begin
						res.emit  = 1'b1;
						res.kind  = KIND_DOUBLE;
						res.phase = PH_IDLE;
					end else begin
						elapsed_next = '0;
						res.phase    = dct_zero ? PH_IDLE : PH_WINDOW;
						res.emit     = dct_zero;
					end
				end else if (long_hit) begin
					res.emit  = 1'b1;
					res.kind  = held_kind;
					res.phase = PH_DRAIN;
				end
			end
			PH_WINDOW: begin
				elapsed_next = e_t;
				if (win_over) begin
					// sample on the closing tick is ignored
					res.emit  = 1'b1;
					res.phase = PH_IDLE;
				end else if (pressed) begin
					elapsed_next = '0;
					if (!deb_zero) begin
						res.phase = PH_SETTLE2;
					end else if (!long_zero) begin
						res.phase = PH_HOLD2;
					end else begin
						res.emit  = 1'b1;
						res.kind  = KIND_DOUBLE;
						res.phase = PH_DRAIN;
					end
				end
			end
			PH_DRAIN: begin
				if (!pressed) begin
					res.phase = PH_IDLE;
				end
			end
			default: begin
				// idle and the unused code
				res.phase = PH_IDLE;
				if (pressed) begin
					elapsed_next = '0;
					if (!deb_zero) begin
						res.phase = PH_SETTLE1;
					end else if (!long_zero) begin
						res.phase = PH_HOLD1;
					end else begin
						res.emit  = 1'b1;
						res.kind  = KIND_LONG;
						res.phase = PH_DRAIN;
					end
				end
			end
		endcase
	end

endmodule

// ===== sv/button_press_classifier_top.sv =====
// button_press_classifier_top: short / long / double press classifier
// depends on bpc_pkg, bpc_cfg_regs, bpc_in_stage, bpc_step
//
// channel   | handshake            | word
// ----------+----------------------+--------------------------------
// input     | in_valid / in_ready  | pressed, one sample per tick
// result    | out_valid / out_ready| press_kind (0 short 1 long 2 double)
// config    | cfg_we               | cfg_index, cfg_data, no read-back
//
// one sample word is taken every clock cycle unless a held result stalls the
// step; the phase/timer loop closes through the combinational bpc_step, so
// throughput is one word per cycle while the result side keeps up; an accepted
// sample sits in the input register, then the step loads the result register
// arst_n clears phase, timer, both valid flags and the thresholds to defaults
// a held result stalls the step; the input register still takes one more word
module button_press_classifier_top import bpc_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// sample channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  pressed,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [KIND_W-1:0]     press_kind,
	// configuration writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t                  cfg;
	logic                  valid_s1;
	logic                  pressed_s1;
	logic                  advance;
	logic                  fire_s1;
	step_res_t             res;
	logic [TIMER_BITS-1:0] elapsed_next;

	// classifier state
	logic [PHASE_W-1:0]    phase_q;
	logic [TIMER_BITS-1:0] elapsed_q;

	// result register
	logic                  out_valid_q;
	logic [KIND_W-1:0]     kind_q;

	// step may run when the result register is empty or being emptied
	assign advance = !out_valid_q || out_ready;
	assign fire_s1 = advance && valid_s1;

	bpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bpc_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pressed    (pressed),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.pressed_s1 (pressed_s1)
	);

	bpc_step #(
		.TIMER_BITS (TIMER_BITS)
	) u_step (
		.cfg          (cfg),
		.phase        (phase_q),
		.elapsed      (elapsed_q),
		.pressed      (pressed_s1),
		.res          (res),
		.elapsed_next (elapsed_next)
	);

	// phase and settle/hold/window timer advance once per classified sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			elapsed_q <= '0;
		end else if (fire_s1) begin
			phase_q   <= res.phase;
			elapsed_q <= elapsed_next;
		end
	end

	// result register: valid updated whenever the step may run; kind loaded only on ticks that classify a press
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire_s1 && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && res.emit) begin
			kind_q <= res.kind;
		end
	end

	assign out_valid  = out_valid_q;
	assign press_kind = kind_q;

	// a long press always leaves the block waiting for release
	a_long_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && res.emit && res.kind == KIND_LONG) |=> (phase_q == PH_DRAIN))
		else $error("long press did not enter drain");

	// an idle tick with the button up never produces a result
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && phase_q == PH_IDLE && !pressed_s1) |=> !out_valid_q)
		else $error("result from idle release");

	// input side stalls only behind a held result and a full input register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without backpressure");

	// only the three defined kinds leave the block
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (press_kind == KIND_SHORT || press_kind == KIND_LONG ||
			press_kind == KIND_DOUBLE))
		else $error("undefined press kind");

endmodule
